// ===== sv/mau_pkg.sv =====
// Package for the modular arithmetic unit: widths, codes, command and status types.
`timescale 1ns / 1ps

package mau_pkg;

    localparam int VALUE_BITS = 31;
    localparam int EXP_BITS   = 63;
    localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);

    localparam logic [VALUE_BITS-1:0] MODULUS_RESET = VALUE_BITS'(1000000007);

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_POW = 3'd3,
        MODE_INV = 3'd4,
        MODE_DIV = 3'd5,
        MODE_NEG = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        MSEL_RED_A,
        MSEL_RED_B,
        MSEL_ACC_SQ,
        MSEL_SQ_SQ,
        MSEL_A_B,
        MSEL_A_ACC
    } t_msel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_A,
        S_RED_A_W,
        S_RED_B,
        S_RED_B_W,
        S_DISPATCH,
        S_POW_CHK,
        S_POW_MUL_W,
        S_POW_SQ,
        S_POW_SQ_W,
        S_DIV_MUL_W,
        S_MUL_W,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic  load;
        logic  mul_start;
        t_msel msel;
        logic  pow_init;
        logic  pow_from_b;
        logic  pow_fermat;
        logic  e_shift;
        logic  finish;
    } t_dp_cmd;

    typedef struct packed {
        logic  mul_done;
        logic  e_zero;
        logic  e_lsb;
        logic  m_small;
        logic  a_zero;
        logic  b_zero;
        logic  [2:0] mode;
    } t_dp_stat;

endpackage

// ===== sv/mau_dp.sv =====
// Datapath of the modular arithmetic unit: operand registers and bit-serial modular multiplier.
`timescale 1ns / 1ps

module mau_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mau_pkg::VALUE_BITS-1:0]      i_cfg_data,
    input  logic [2:0]                          i_mode,
    input  logic [mau_pkg::VALUE_BITS-1:0]      i_operand_a,
    input  logic [mau_pkg::VALUE_BITS-1:0]      i_operand_b,
    input  logic [mau_pkg::EXP_BITS-1:0]        i_exponent,
    input  mau_pkg::t_dp_cmd                    i_cmd,
    output mau_pkg::t_dp_stat                   o_stat,
    output logic [mau_pkg::VALUE_BITS-1:0]      o_result
);

    localparam int W = mau_pkg::VALUE_BITS;

    logic [W-1:0]                   r_mod;
    logic [2:0]                     r_mode;
    logic [W-1:0]                   r_a;
    logic [W-1:0]                   r_b;
    logic [W-1:0]                   r_acc;
    logic [W-1:0]                   r_sq;
    logic [mau_pkg::EXP_BITS-1:0]   r_e;
    logic [W-1:0]                   r_res;

    logic [W-1:0]                   r_mx;
    logic [W-1:0]                   r_my;
    logic [W-1:0]                   r_mp;
    logic [mau_pkg::CNT_BITS-1:0]   r_cnt;
    mau_pkg::t_msel                 r_msel;
    logic                           r_mul_done;

    logic [W-1:0]                   n_mx;
    logic [W-1:0]                   n_my;
    logic [W+1:0]                   n_t;
    logic [W+1:0]                   n_m1;
    logic [W+1:0]                   n_m2;
    logic [W-1:0]                   n_mp;
    logic                           n_last;
    logic [W:0]                     n_sum;
    logic [W:0]                     n_dif;
    logic [W-1:0]                   n_res;

    always_comb begin
        unique case (i_cmd.msel)
            mau_pkg::MSEL_RED_A: begin
                n_mx = W'(1);
                n_my = r_a;
            end
            mau_pkg::MSEL_RED_B: begin
                n_mx = W'(1);
                n_my = r_b;
            end
            mau_pkg::MSEL_ACC_SQ: begin
                n_mx = r_sq;
                n_my = r_acc;
            end
            mau_pkg::MSEL_SQ_SQ: begin
                n_mx = r_sq;
                n_my = r_sq;
            end
            mau_pkg::MSEL_A_B: begin
                n_mx = r_a;
                n_my = r_b;
            end
            mau_pkg::MSEL_A_ACC: begin
                n_mx = r_a;
                n_my = r_acc;
            end
            default: begin
                n_mx = W'(1);
                n_my = r_a;
            end
        endcase
    end

    // One multiplier bit per cycle: double, add, and fold back below the modulus.
    always_comb begin
        n_t  = {1'b0, r_mp, 1'b0} + (r_my[W-1] ? {2'b00, r_mx} : '0);
        n_m1 = {2'b00, r_mod};
        n_m2 = {1'b0, r_mod, 1'b0};
        if (n_t >= n_m2) begin
            n_mp = W'(n_t - n_m2);
        end else if (n_t >= n_m1) begin
            n_mp = W'(n_t - n_m1);
        end else begin
            n_mp = W'(n_t);
        end
        n_last = (r_cnt == mau_pkg::CNT_BITS'(1));
    end

    always_comb begin
        n_sum = {1'b0, r_a} + {1'b0, r_b};
        n_dif = {1'b0, r_a} + {1'b0, r_mod} - {1'b0, r_b};
        case (mau_pkg::t_mode'(r_mode)) inside
            mau_pkg::MODE_ADD: begin
                n_res = (n_sum >= {1'b0, r_mod}) ? W'(n_sum - {1'b0, r_mod}) : W'(n_sum);
            end
            mau_pkg::MODE_SUB: begin
                n_res = (r_a >= r_b) ? (r_a - r_b) : W'(n_dif);
            end
            mau_pkg::MODE_NEG: begin
                n_res = (r_a == '0) ? '0 : (r_mod - r_a);
            end
            mau_pkg::MODE_MUL, mau_pkg::MODE_POW: begin
                n_res = r_acc;
            end
            mau_pkg::MODE_INV: begin
                n_res = (r_a == '0) ? '0 : r_acc;
            end
            mau_pkg::MODE_DIV: begin
                n_res = (r_b == '0) ? '0 : r_acc;
            end
            default: begin
                n_res = '0;
            end
        endcase
        if (r_mod < W'(2)) begin
            n_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod      <= mau_pkg::MODULUS_RESET;
            r_cnt      <= '0;
            r_mul_done <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mod <= i_cfg_data;
            end
            r_mul_done <= 1'b0;
            if (i_cmd.mul_start) begin
                r_cnt <= mau_pkg::CNT_BITS'(W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - mau_pkg::CNT_BITS'(1);
                if (n_last) begin
                    r_mul_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_a    <= i_operand_a;
            r_b    <= i_operand_b;
            r_e    <= i_exponent;
        end
        if (i_cmd.mul_start) begin
            r_mx   <= n_mx;
            r_my   <= n_my;
            r_mp   <= '0;
            r_msel <= i_cmd.msel;
        end else if (r_cnt != '0) begin
            r_my <= {r_my[W-2:0], 1'b0};
            r_mp <= n_mp;
            if (n_last) begin
                case (r_msel)
                    mau_pkg::MSEL_RED_A: r_a   <= n_mp;
                    mau_pkg::MSEL_RED_B: r_b   <= n_mp;
                    mau_pkg::MSEL_SQ_SQ: r_sq  <= n_mp;
                    default:             r_acc <= n_mp;
                endcase
            end
        end
        if (i_cmd.pow_init) begin
            r_acc <= W'(1);
            r_sq  <= i_cmd.pow_from_b ? r_b : r_a;
            if (i_cmd.pow_fermat) begin
                r_e <= {{(mau_pkg::EXP_BITS - W){1'b0}}, r_mod - W'(2)};
            end
        end
        if (i_cmd.e_shift) begin
            r_e <= {1'b0, r_e[mau_pkg::EXP_BITS-1:1]};
        end
        if (i_cmd.finish) begin
            r_res <= n_res;
        end
    end

    assign o_stat.mul_done = r_mul_done;
    assign o_stat.e_zero   = (r_e == '0);
    assign o_stat.e_lsb    = r_e[0];
    assign o_stat.m_small  = (r_mod < W'(2));
    assign o_stat.a_zero   = (r_a == '0);
    assign o_stat.b_zero   = (r_b == '0);
    assign o_stat.mode     = r_mode;
    assign o_result        = r_res;

    a_mx_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_mx < r_mod))
        else $error("multiplicand not reduced during a multiply");

    a_mp_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_mp < r_mod))
        else $error("partial product escaped the modulus range");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_done |-> $past(r_cnt) == mau_pkg::CNT_BITS'(1))
        else $error("multiply done without a final step");

endmodule

// ===== sv/mau_ctrl.sv =====
// Controller of the modular arithmetic unit: operation sequencing and handshakes.
`timescale 1ns / 1ps

module mau_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    input  mau_pkg::t_dp_stat   i_stat,
    output mau_pkg::t_dp_cmd    o_cmd
);

    mau_pkg::t_state r_state;
    mau_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mau_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd       = '0;
        o_cmd.msel  = mau_pkg::MSEL_RED_A;
        o_ready     = 1'b0;
        unique case (r_state) inside
            mau_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = mau_pkg::S_RED_A;
                end
            end
            mau_pkg::S_RED_A: begin
                if (i_stat.m_small) begin
                    n_state = mau_pkg::S_FINISH;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.msel      = mau_pkg::MSEL_RED_A;
                    n_state         = mau_pkg::S_RED_A_W;
                end
            end
            mau_pkg::S_RED_A_W: begin
                if (i_stat.mul_done) begin
                    n_state = mau_pkg::S_RED_B;
                end
            end
            mau_pkg::S_RED_B: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.msel      = mau_pkg::MSEL_RED_B;
                n_state         = mau_pkg::S_RED_B_W;
            end
            mau_pkg::S_RED_B_W: begin
                if (i_stat.mul_done) begin
                    n_state = mau_pkg::S_DISPATCH;
                end
            end
            mau_pkg::S_DISPATCH: begin
                case (mau_pkg::t_mode'(i_stat.mode))
                    mau_pkg::MODE_MUL: begin
                        o_cmd.mul_start = 1'b1;
                        o_cmd.msel      = mau_pkg::MSEL_A_B;
                        n_state         = mau_pkg::S_MUL_W;
                    end
                    mau_pkg::MODE_POW: begin
                        o_cmd.pow_init = 1'b1;
                        n_state        = mau_pkg::S_POW_CHK;
                    end
                    mau_pkg::MODE_INV: begin
                        if (i_stat.a_zero) begin
                            n_state = mau_pkg::S_FINISH;
                        end else begin
                            o_cmd.pow_init   = 1'b1;
                            o_cmd.pow_fermat = 1'b1;
                            n_state          = mau_pkg::S_POW_CHK;
                        end
                    end
                    mau_pkg::MODE_DIV: begin
                        if (i_stat.b_zero) begin
                            n_state = mau_pkg::S_FINISH;
                        end else begin
                            o_cmd.pow_init   = 1'b1;
                            o_cmd.pow_from_b = 1'b1;
                            o_cmd.pow_fermat = 1'b1;
                            n_state          = mau_pkg::S_POW_CHK;
                        end
                    end
                    default: begin
                        n_state = mau_pkg::S_FINISH;
                    end
                endcase
            end
            mau_pkg::S_POW_CHK: begin
                if (i_stat.e_zero) begin
                    if (mau_pkg::t_mode'(i_stat.mode) == mau_pkg::MODE_DIV) begin
                        o_cmd.mul_start = 1'b1;
                        o_cmd.msel      = mau_pkg::MSEL_A_ACC;
                        n_state         = mau_pkg::S_DIV_MUL_W;
                    end else begin
                        n_state = mau_pkg::S_FINISH;
                    end
                end else if (i_stat.e_lsb) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.msel      = mau_pkg::MSEL_ACC_SQ;
                    n_state         = mau_pkg::S_POW_MUL_W;
                end else begin
                    n_state = mau_pkg::S_POW_SQ;
                end
            end
            mau_pkg::S_POW_MUL_W: begin
                if (i_stat.mul_done) begin
                    n_state = mau_pkg::S_POW_SQ;
                end
            end
            mau_pkg::S_POW_SQ: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.msel      = mau_pkg::MSEL_SQ_SQ;
                o_cmd.e_shift   = 1'b1;
                n_state         = mau_pkg::S_POW_SQ_W;
            end
            mau_pkg::S_POW_SQ_W: begin
                if (i_stat.mul_done) begin
                    n_state = mau_pkg::S_POW_CHK;
                end
            end
            mau_pkg::S_DIV_MUL_W, mau_pkg::S_MUL_W: begin
                if (i_stat.mul_done) begin
                    n_state = mau_pkg::S_FINISH;
                end
            end
            mau_pkg::S_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = mau_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mau_pkg::S_IDLE;
            end
        endcase
    end

    assign o_valid = r_out_valid;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.mul_done |-> (r_state == mau_pkg::S_RED_A_W || r_state == mau_pkg::S_RED_B_W
            || r_state == mau_pkg::S_POW_MUL_W || r_state == mau_pkg::S_POW_SQ_W
            || r_state == mau_pkg::S_DIV_MUL_W || r_state == mau_pkg::S_MUL_W))
        else $error("multiply completed outside a wait state");

    a_valid_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == mau_pkg::S_FINISH)
        else $error("result raised outside the finish step");

    a_finish_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mau_pkg::S_FINISH && r_out_valid && !i_ready)
            |=> r_state == mau_pkg::S_FINISH)
        else $error("finish left while the previous result was still held");

endmodule

// ===== sv/modular_arithmetic_unit.sv =====
// Top level of the modular arithmetic unit: controller and datapath.
//
//  Channel   | Valid / ready          | Data
//  ----------+------------------------+----------------------------------------------
//  input     | i_valid / o_ready      | i_mode, i_operand_a, i_operand_b, i_exponent
//  result    | o_valid / i_ready      | o_result
//  config    | i_cfg_valid / o_cfg_ready | i_cfg_data (modulus)
//
// One item is in work at a time. Each modular multiply runs in the bit-serial
// shift-add multiplier, one multiplier bit per cycle, and both operands are first reduced
// by one such pass each. Add, subtract and negate follow the two reduction passes; power,
// inverse and divide then square per exponent bit and multiply per set bit.
// Reset returns the modulus to 1000000007 and needs no clearing time. A result waiting
// for transfer holds back only the completion of the next item.
`timescale 1ns / 1ps

module modular_arithmetic_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [2:0]                      i_mode,
    input  logic [mau_pkg::VALUE_BITS-1:0]  i_operand_a,
    input  logic [mau_pkg::VALUE_BITS-1:0]  i_operand_b,
    input  logic [mau_pkg::EXP_BITS-1:0]    i_exponent,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mau_pkg::VALUE_BITS-1:0]  o_result,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mau_pkg::VALUE_BITS-1:0]  i_cfg_data
);

    mau_pkg::t_dp_cmd  w_cmd;
    mau_pkg::t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    mau_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    mau_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_mode      (i_mode),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_exponent  (i_exponent),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_result    (o_result)
    );

endmodule

// ===== dv/modular_arithmetic_unit_test.sv =====
// Self-checking testbench for the modular arithmetic unit with its own result predictor.
`timescale 1ns / 1ps

module modular_arithmetic_unit_test;

    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam int HOLD_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int END_CYCLES    = 100;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [2:0]                     mode;
        logic [mau_pkg::VALUE_BITS-1:0] operand_a;
        logic [mau_pkg::VALUE_BITS-1:0] operand_b;
        logic [mau_pkg::EXP_BITS-1:0]   exponent;
    } t_arith_item;

    typedef struct packed {
        t_arith_item                    item;
        logic [mau_pkg::VALUE_BITS-1:0] value;
    } t_arith_expect;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    logic [2:0]                     i_mode = '0;
    logic [mau_pkg::VALUE_BITS-1:0] i_operand_a = '0;
    logic [mau_pkg::VALUE_BITS-1:0] i_operand_b = '0;
    logic [mau_pkg::EXP_BITS-1:0]   i_exponent = '0;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    logic [mau_pkg::VALUE_BITS-1:0] o_result;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [mau_pkg::VALUE_BITS-1:0] i_cfg_data = '0;

    t_arith_item   pending_q[$];
    t_arith_expect expected_q[$];
    logic [mau_pkg::VALUE_BITS-1:0] model_modulus = mau_pkg::MODULUS_RESET;

    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    int   fail_count = 0;
    int   reports = 0;
    int   idle_cycles = 0;
    int   hold_requests = 0;
    int   holds_started = 0;
    int   in_gap = 0;
    logic in_burst = 1'b0;
    int   sink_wait = 0;
    int   hold_left = 0;
    logic sink_burst = 1'b0;

    modular_arithmetic_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_mode      (i_mode),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_exponent  (i_exponent),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [63:0] pow_mod(input logic [63:0] base,
                                            input logic [mau_pkg::EXP_BITS-1:0] e,
                                            input logic [63:0] m);
        logic [63:0] acc;
        logic [63:0] sq;
        acc = 64'd1 % m;
        sq = base % m;
        for (int i = 0; i < mau_pkg::EXP_BITS; i++) begin
            if (e[i]) begin
                acc = (acc * sq) % m;
            end
            sq = (sq * sq) % m;
        end
        return acc;
    endfunction

    function automatic logic [63:0] inverse_mod(input logic [63:0] x, input logic [63:0] m);
        if (x == 64'd0) begin
            return 64'd0;
        end
        return pow_mod(x, mau_pkg::EXP_BITS'(m - 64'd2), m);
    endfunction

    function automatic logic [mau_pkg::VALUE_BITS-1:0] predict_result(
        input t_arith_item it, input logic [mau_pkg::VALUE_BITS-1:0] modv);
        logic [63:0] m;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        m = 64'(modv);
        if (m < 64'd2) begin
            return '0;
        end
        a = 64'(it.operand_a) % m;
        b = 64'(it.operand_b) % m;
        case (it.mode)
            mau_pkg::MODE_ADD: r = (a + b) % m;
            mau_pkg::MODE_SUB: r = (a + (m - b)) % m;
            mau_pkg::MODE_MUL: r = (a * b) % m;
            mau_pkg::MODE_POW: r = pow_mod(a, it.exponent, m);
            mau_pkg::MODE_INV: r = inverse_mod(a, m);
            mau_pkg::MODE_DIV: r = (a * inverse_mod(b, m)) % m;
            mau_pkg::MODE_NEG: r = (a != 64'd0) ? (m - a) : 64'd0;
            default:           r = 64'd0;
        endcase
        return r[mau_pkg::VALUE_BITS-1:0];
    endfunction

    function automatic logic [mau_pkg::VALUE_BITS-1:0] pick_operand(
        input logic [mau_pkg::VALUE_BITS-1:0] m);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return mau_pkg::VALUE_BITS'(1);
            2: return m - mau_pkg::VALUE_BITS'(1);
            3: return m;
            4: return '1;
            default: return mau_pkg::VALUE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [mau_pkg::EXP_BITS-1:0] pick_exponent();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return mau_pkg::EXP_BITS'($urandom_range(1, 64));
            default: return mau_pkg::EXP_BITS'({$urandom, $urandom});
        endcase
    endfunction

    task automatic queue_item(input logic [2:0] mode,
                              input logic [mau_pkg::VALUE_BITS-1:0] a,
                              input logic [mau_pkg::VALUE_BITS-1:0] b,
                              input logic [mau_pkg::EXP_BITS-1:0] e);
        t_arith_item it;
        it.mode = mode;
        it.operand_a = a;
        it.operand_b = b;
        it.exponent = e;
        pending_q.push_back(it);
    endtask

    task automatic queue_random(input int count);
        logic [2:0] mode;
        for (int i = 0; i < count; i++) begin
            mode = ($urandom_range(0, 15) == 0) ? MODE_UNUSED : 3'($urandom_range(0, 6));
            queue_item(mode, pick_operand(model_modulus), pick_operand(model_modulus),
                       pick_exponent());
        end
    endtask

    task automatic drain_results();
        while (pending_q.size() != 0 || i_valid || expected_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_modulus(input logic [mau_pkg::VALUE_BITS-1:0] value);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        model_modulus = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin : item_driver
        t_arith_item it;
        if (!(i_valid && !in_taken)) begin
            if (in_gap > 0) begin
                in_gap--;
                i_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                it = pending_q.pop_front();
                i_mode <= it.mode;
                i_operand_a <= it.operand_a;
                i_operand_b <= it.operand_b;
                i_exponent <= it.exponent;
                i_valid <= 1'b1;
                if ($urandom_range(0, 7) == 0) begin
                    in_burst = !in_burst;
                end
                in_gap = in_burst ? 0 : $urandom_range(0, 7);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : result_sink
        logic next_ready;
        if (hold_requests != holds_started) begin
            hold_left = HOLD_CYCLES;
            holds_started++;
        end
        if (out_taken) begin
            if ($urandom_range(0, 7) == 0) begin
                sink_burst = !sink_burst;
            end
            sink_wait = sink_burst ? 0 : $urandom_range(0, 7);
        end
        if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait--;
            next_ready = 1'b0;
        end else begin
            next_ready = 1'b1;
        end
        i_ready <= next_ready;
    end

    always @(posedge i_clk) begin : transfer_monitor
        t_arith_item   it;
        t_arith_expect want;
        in_taken = 1'b0;
        out_taken = 1'b0;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                in_taken = 1'b1;
                it.mode = i_mode;
                it.operand_a = i_operand_a;
                it.operand_b = i_operand_b;
                it.exponent = i_exponent;
                want.item = it;
                want.value = predict_result(it, model_modulus);
                expected_q.push_back(want);
            end
            if (o_valid && i_ready) begin
                out_taken = 1'b1;
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (reports < REPORT_LIMIT) begin
                        reports++;
                        $display("Unexpected result transfer: actual %0d", o_result);
                    end
                end else begin
                    want = expected_q.pop_front();
                    if (o_result !== want.value) begin
                        fail_count++;
                        if (reports < REPORT_LIMIT) begin
                            reports++;
                            $display({"Result mismatch (mode %0d, a %0d, b %0d, e %0d): ",
                                      "expected %0d, actual %0d"},
                                     want.item.mode, want.item.operand_a,
                                     want.item.operand_b, want.item.exponent,
                                     want.value, o_result);
                        end
                    end
                end
            end
            if (in_taken || out_taken || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_item(mau_pkg::MODE_ADD, '1, '1, '0);
        queue_item(mau_pkg::MODE_ADD, mau_pkg::MODULUS_RESET - 31'd1, 31'd1, '0);
        queue_item(mau_pkg::MODE_SUB, '0, 31'd1, '0);
        queue_item(mau_pkg::MODE_SUB, 31'd5, '1, '0);
        queue_item(mau_pkg::MODE_MUL, mau_pkg::MODULUS_RESET - 31'd1,
                   mau_pkg::MODULUS_RESET - 31'd1, '0);
        queue_item(mau_pkg::MODE_MUL, '1, '1, '1);
        queue_item(mau_pkg::MODE_POW, '0, '0, '0);
        queue_item(mau_pkg::MODE_POW, '0, '1, 63'd5);
        queue_item(mau_pkg::MODE_POW, 31'd2, '0, '1);
        queue_item(mau_pkg::MODE_POW, 31'd3, '0, 63'd1);
        queue_item(mau_pkg::MODE_POW, '1, '0, {1'b1, 62'd0});
        queue_item(mau_pkg::MODE_INV, '0, '0, '0);
        queue_item(mau_pkg::MODE_INV, 31'd1, '0, '0);
        queue_item(mau_pkg::MODE_INV, mau_pkg::MODULUS_RESET, '0, '0);
        queue_item(mau_pkg::MODE_INV, '1, '1, '0);
        queue_item(mau_pkg::MODE_DIV, 31'd10, '0, '0);
        queue_item(mau_pkg::MODE_DIV, 31'd10, 31'd3, '0);
        queue_item(mau_pkg::MODE_DIV, '1, mau_pkg::MODULUS_RESET, '0);
        queue_item(mau_pkg::MODE_NEG, '0, '0, '0);
        queue_item(mau_pkg::MODE_NEG, mau_pkg::MODULUS_RESET, '0, '0);
        queue_item(mau_pkg::MODE_NEG, 31'd1, '0, '0);
        queue_item(mau_pkg::MODE_NEG, '1, '0, '0);
        queue_item(MODE_UNUSED, '1, '1, '1);
        queue_random(35);
        hold_requests++;

        write_modulus('1);
        queue_item(mau_pkg::MODE_POW, '1, '1, '1);
        queue_item(mau_pkg::MODE_INV, '1 - 31'd1, '0, '0);
        queue_random(22);

        write_modulus(31'd2);
        queue_random(14);

        write_modulus('0);
        queue_random(6);

        write_modulus(31'd1);
        queue_random(6);

        write_modulus(31'd13);
        queue_random(20);
        hold_requests++;

        write_modulus(31'd1000);
        queue_random(12);

        drain_results();
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
